// ----- sv/bca_pkg.sv -----
// shared types, widths and step codes for the cubic bezier arc length block
`default_nettype none

package bca_pkg;

    localparam int COORD_W     = 24;
    localparam int N_W         = 8;
    localparam int CNT_W       = 12;
    localparam int MAX_SAMPLES = 255;
    localparam int LEN_W       = 27;
    localparam int SUM_W       = LEN_W + 1;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam int T_W        = 16;
    localparam int U_W        = T_W + 1;
    localparam int DIV_W      = N_W + 1;
    localparam int DIV_STEPS  = T_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam logic [U_W-1:0] ONE_Q16 = {1'b1, {T_W{1'b0}}};

    localparam int SQP_W = 2 * U_W;
    localparam int W_W   = 33;
    localparam int WR_W  = 50;
    localparam logic [WR_W-1:0] ROUND_W = WR_W'(32'h8000);

    localparam int MA_W = 35;
    localparam int MB_W = 26;
    localparam int MP_W = MA_W + MB_W;
    localparam logic signed [MP_W-1:0] ROUND_C = MP_W'(64'sh8000_0000);

    localparam int D_W = 26;
    localparam int SQ_W       = 52;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = SQRT_STEPS + 3;
    localparam int SCNT_W     = $clog2(SQRT_STEPS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // multiply sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] MS_UU  = 5'd0;
    localparam logic [STEP_W-1:0] MS_TT  = 5'd1;
    localparam logic [STEP_W-1:0] MS_U3  = 5'd2;
    localparam logic [STEP_W-1:0] MS_T3  = 5'd3;
    localparam logic [STEP_W-1:0] MS_U2T = 5'd4;
    localparam logic [STEP_W-1:0] MS_T2U = 5'd5;
    localparam logic [STEP_W-1:0] MS_X0  = 5'd6;
    localparam logic [STEP_W-1:0] MS_X1  = 5'd7;
    localparam logic [STEP_W-1:0] MS_X2  = 5'd8;
    localparam logic [STEP_W-1:0] MS_X3  = 5'd9;
    localparam logic [STEP_W-1:0] MS_Y0  = 5'd10;
    localparam logic [STEP_W-1:0] MS_Y1  = 5'd11;
    localparam logic [STEP_W-1:0] MS_Y2  = 5'd12;
    localparam logic [STEP_W-1:0] MS_Y3  = 5'd13;
    localparam logic [STEP_W-1:0] MS_DXX = 5'd14;
    localparam logic [STEP_W-1:0] MS_DYS = 5'd15;
    localparam logic [STEP_W-1:0] MS_DYY = 5'd16;
    localparam logic [STEP_W-1:0] MS_LAST = 5'd17;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t         start_x;
        coord_t         start_y;
        coord_t         ctrl_a_x;
        coord_t         ctrl_a_y;
        coord_t         ctrl_b_x;
        coord_t         ctrl_b_y;
        coord_t         end_x;
        coord_t         end_y;
        logic [N_W-1:0] sample_count;
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0] arc_length;
        logic             saturated;
    } rsp_t;

    typedef struct packed {
        coord_t         cx0;
        coord_t         cy0;
        coord_t         cx1;
        coord_t         cy1;
        coord_t         cx2;
        coord_t         cy2;
        coord_t         cx3;
        coord_t         cy3;
        logic [N_W-1:0] n;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } qport_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SQRT,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/bca_req_if.sv -----
// request channel carrying the control points and sample count
`default_nettype none

interface bca_req_if;
    import bca_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/bca_rsp_if.sv -----
// result channel carrying the arc length
`default_nettype none

interface bca_rsp_if;
    import bca_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/cubic_bezier_arc_length_top.sv -----
// cubic bezier polyline arc length, top level
// req carries the four control points (signed Q16.8) and the interior sample
// count; a request is taken when req.valid and req.ready are both high.
// rsp returns one result per request: the summed chord length (Q19.8) and a
// flag that is set when the sum clipped at its maximum.
// the front end clamps the sample count and writes a two-entry queue, so two
// requests can wait while the engine works on a third.
// each interior sample passes through the parameter divider, the shared
// multiplier, the bit-serial square root and the sum; the closing chord skips
// the divider and enters the multiplier sequence partway through. the engine
// works on one request at a time and takes the next from the queue only once
// the result of the last has been loaded into the output register.
// reset empties the queue, drops any result held in the output register and
// returns the engine to idle.
// a stalled receiver holds the result in the output register; the engine
// finishes its current request and then waits until the register frees.
`default_nettype none

module cubic_bezier_arc_length_top (
    input  logic       clk,
    input  logic       rst_n,
    bca_req_if.sink    req,
    bca_rsp_if.source  rsp
);
    import bca_pkg::*;

    qport_t qwr;
    qport_t qrd;
    logic   q_full;
    logic   q_pop;

    bca_front u_front (
        .req    (req),
        .q_full (q_full),
        .qwr    (qwr)
    );

    bca_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qwr   (qwr),
        .full  (q_full),
        .qrd   (qrd),
        .pop   (q_pop)
    );

    bca_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qrd     (qrd),
        .job_pop (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// ----- sv/bca_front.sv -----
// front end: takes requests, limits the sample count and forms queue entries
`default_nettype none

module bca_front (
    bca_req_if.sink          req,
    input  logic             q_full,
    output bca_pkg::qport_t  qwr
);
    import bca_pkg::*;

    logic [CNT_W-1:0] cnt_ext;
    logic [N_W-1:0]   n_lim;

    assign cnt_ext = CNT_W'(req.data.sample_count);

    always_comb
    begin
        if (cnt_ext > CNT_W'(MAX_SAMPLES))
        begin
            n_lim = N_W'(MAX_SAMPLES);
        end
        else
        begin
            n_lim = req.data.sample_count;
        end
    end

    assign req.ready     = !q_full;
    assign qwr.valid     = req.valid && !q_full;
    assign qwr.job.cx0   = req.data.start_x;
    assign qwr.job.cy0   = req.data.start_y;
    assign qwr.job.cx1   = req.data.ctrl_a_x;
    assign qwr.job.cy1   = req.data.ctrl_a_y;
    assign qwr.job.cx2   = req.data.ctrl_b_x;
    assign qwr.job.cy2   = req.data.ctrl_b_y;
    assign qwr.job.cx3   = req.data.end_x;
    assign qwr.job.cy3   = req.data.end_y;
    assign qwr.job.n     = n_lim;

endmodule

`default_nettype wire

// ----- sv/bca_queue.sv -----
// short job queue between front end and evaluation engine
`default_nettype none

module bca_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  bca_pkg::qport_t  qwr,
    output logic             full,
    output bca_pkg::qport_t  qrd,
    input  logic             pop
);
    import bca_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push  = qwr.valid && !full;
    assign do_pop   = pop && (cnt_reg != '0);
    assign qrd.valid = (cnt_reg != '0);
    assign qrd.job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= qwr.job;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push && cnt_reg == QCNT_W'(1)) |=> !qrd.valid)
        else $error("queue shows data after last entry left");

endmodule

`default_nettype wire

// ----- sv/bca_back.sv -----
// evaluation engine: divider, shared multiplier, square root and length sum
`default_nettype none

module bca_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bca_pkg::qport_t  qrd,
    output logic             job_pop,
    bca_rsp_if.source        rsp
);
    import bca_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_load;

    job_t               job_reg;
    logic [N_W-1:0]     i_reg;
    logic               final_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SCNT_W-1:0]  scnt_reg;

    logic [DIV_W-1:0]   div_rem_reg;
    logic [T_W-1:0]     q_reg;
    logic [DIV_W-1:0]   divisor;
    logic [DIV_W:0]     rem_dbl;
    logic               rem_ge;

    logic [U_W-1:0]     u;
    logic [SQP_W-1:0]   u2_reg;
    logic [SQP_W-1:0]   t2_reg;
    logic [W_W-1:0]     w0_reg;
    logic [W_W-1:0]     w1_reg;
    logic [W_W-1:0]     w2_reg;
    logic [W_W-1:0]     w3_reg;
    logic [WR_W-1:0]    p_lo;
    logic [WR_W-1:0]    w_r1;
    logic [WR_W-1:0]    w_r3;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod_reg;
    logic signed [MP_W-1:0] accx_reg;
    logic signed [MP_W-1:0] accy_reg;
    logic signed [MP_W-1:0] rndx;
    logic signed [MP_W-1:0] rndy;
    logic signed [D_W-1:0]  px;
    logic signed [D_W-1:0]  py;
    logic signed [D_W-1:0]  px_reg;
    logic signed [D_W-1:0]  py_reg;
    logic signed [D_W-1:0]  lx_reg;
    logic signed [D_W-1:0]  ly_reg;
    logic signed [D_W-1:0]  dx_reg;
    logic signed [D_W-1:0]  dy_reg;

    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    val_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    logic [LEN_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_add;
    logic               rsp_valid_reg;
    rsp_t               rsp_data_reg;

    assign divisor = DIV_W'(job_reg.n) + 1'b1;
    assign rem_dbl = {div_rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, divisor});
    assign u       = ONE_Q16 - U_W'(q_reg);

    assign p_lo = prod_reg[WR_W-1:0];
    assign w_r1 = p_lo + ROUND_W;
    assign w_r3 = p_lo + {p_lo[WR_W-2:0], 1'b0} + ROUND_W;

    assign rndx = accx_reg + ROUND_C;
    assign rndy = accy_reg + ROUND_C;
    assign px   = final_reg ? D_W'(job_reg.cx3) : rndx[32+D_W-1:32];
    assign py   = final_reg ? D_W'(job_reg.cy3) : rndy[32+D_W-1:32];

    assign rem_sh  = {rem_reg[REM_W-3:0], val_reg[SQ_W-1:SQ_W-2]};
    assign trial   = REM_W'({root_reg, 2'b01});
    assign sum_add = SUM_W'(sum_reg) + SUM_W'(root_reg);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            MS_UU:
            begin
                mul_a = $signed({{(MA_W-U_W){1'b0}}, u});
                mul_b = $signed({{(MB_W-U_W){1'b0}}, u});
            end
            MS_TT:
            begin
                mul_a = $signed({{(MA_W-T_W){1'b0}}, q_reg});
                mul_b = $signed({{(MB_W-T_W){1'b0}}, q_reg});
            end
            MS_U3:
            begin
                mul_a = $signed({{(MA_W-SQP_W){1'b0}}, u2_reg});
                mul_b = $signed({{(MB_W-U_W){1'b0}}, u});
            end
            MS_T3:
            begin
                mul_a = $signed({{(MA_W-SQP_W){1'b0}}, t2_reg});
                mul_b = $signed({{(MB_W-T_W){1'b0}}, q_reg});
            end
            MS_U2T:
            begin
                mul_a = $signed({{(MA_W-SQP_W){1'b0}}, u2_reg});
                mul_b = $signed({{(MB_W-T_W){1'b0}}, q_reg});
            end
            MS_T2U:
            begin
                mul_a = $signed({{(MA_W-SQP_W){1'b0}}, t2_reg});
                mul_b = $signed({{(MB_W-U_W){1'b0}}, u});
            end
            MS_X0:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w0_reg});
                mul_b = MB_W'(job_reg.cx0);
            end
            MS_X1:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w1_reg});
                mul_b = MB_W'(job_reg.cx1);
            end
            MS_X2:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w2_reg});
                mul_b = MB_W'(job_reg.cx2);
            end
            MS_X3:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w3_reg});
                mul_b = MB_W'(job_reg.cx3);
            end
            MS_Y0:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w0_reg});
                mul_b = MB_W'(job_reg.cy0);
            end
            MS_Y1:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w1_reg});
                mul_b = MB_W'(job_reg.cy1);
            end
            MS_Y2:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w2_reg});
                mul_b = MB_W'(job_reg.cy2);
            end
            MS_Y3:
            begin
                mul_a = $signed({{(MA_W-W_W){1'b0}}, w3_reg});
                mul_b = MB_W'(job_reg.cy3);
            end
            MS_DXX:
            begin
                mul_a = MA_W'(dx_reg);
                mul_b = MB_W'(dx_reg);
            end
            MS_DYY:
            begin
                mul_a = MA_W'(dy_reg);
                mul_b = MB_W'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (qrd.valid)
                begin
                    job_pop    = 1'b1;
                    state_next = (qrd.job.n == '0) ? ST_MUL : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == MS_LAST)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (scnt_reg == SCNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (i_reg == job_reg.n)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
            i_reg         <= '0;
            dcnt_reg      <= '0;
            step_reg      <= '0;
            scnt_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        final_reg <= (qrd.job.n == '0);
                        i_reg     <= N_W'(1);
                        dcnt_reg  <= '0;
                        step_reg  <= (qrd.job.n == '0) ? MS_Y1 : MS_UU;
                    end
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    step_reg <= MS_UU;
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    scnt_reg <= '0;
                end
                ST_SQRT:
                begin
                    scnt_reg <= scnt_reg + 1'b1;
                end
                ST_ACC:
                begin
                    if (!final_reg)
                    begin
                        if (i_reg == job_reg.n)
                        begin
                            final_reg <= 1'b1;
                            step_reg  <= MS_Y1;
                        end
                        else
                        begin
                            i_reg    <= i_reg + 1'b1;
                            dcnt_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    final_reg <= final_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_data_reg.arc_length <= sum_reg;
            rsp_data_reg.saturated  <= (sum_reg == LEN_MAX);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_pop)
                begin
                    job_reg     <= qrd.job;
                    lx_reg      <= D_W'(qrd.job.cx0);
                    ly_reg      <= D_W'(qrd.job.cy0);
                    sum_reg     <= '0;
                    div_rem_reg <= DIV_W'(1);
                end
            end
            ST_DIV:
            begin
                div_rem_reg <= rem_ge ? DIV_W'(rem_dbl - {1'b0, divisor}) : DIV_W'(rem_dbl);
                q_reg       <= {q_reg[T_W-2:0], rem_ge};
            end
            ST_MUL:
            begin
                prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
                case (step_reg)
                    MS_TT:  u2_reg <= prod_reg[SQP_W-1:0];
                    MS_U3:  t2_reg <= prod_reg[SQP_W-1:0];
                    MS_T3:  w0_reg <= w_r1[16+W_W-1:16];
                    MS_U2T: w3_reg <= w_r1[16+W_W-1:16];
                    MS_T2U: w1_reg <= w_r3[16+W_W-1:16];
                    MS_X0:  w2_reg <= w_r3[16+W_W-1:16];
                    MS_X1:  accx_reg <= prod_reg;
                    MS_X2:  accx_reg <= accx_reg + prod_reg;
                    MS_X3:  accx_reg <= accx_reg + prod_reg;
                    MS_Y0:  accx_reg <= accx_reg + prod_reg;
                    MS_Y1:
                    begin
                        accy_reg <= prod_reg;
                        px_reg   <= px;
                        dx_reg   <= px - lx_reg;
                    end
                    MS_Y2:  accy_reg <= accy_reg + prod_reg;
                    MS_Y3:  accy_reg <= accy_reg + prod_reg;
                    MS_DXX: accy_reg <= accy_reg + prod_reg;
                    MS_DYS:
                    begin
                        sq_reg <= prod_reg[SQ_W-1:0];
                        py_reg <= py;
                        dy_reg <= py - ly_reg;
                    end
                    MS_LAST:
                    begin
                        val_reg  <= sq_reg + prod_reg[SQ_W-1:0];
                        rem_reg  <= '0;
                        root_reg <= '0;
                        lx_reg   <= px_reg;
                        ly_reg   <= py_reg;
                    end
                    default:
                    begin
                        sq_reg <= sq_reg;
                    end
                endcase
            end
            ST_SQRT:
            begin
                val_reg <= {val_reg[SQ_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            ST_ACC:
            begin
                if (sum_add >= SUM_W'(LEN_MAX))
                begin
                    sum_reg <= LEN_MAX;
                end
                else
                begin
                    sum_reg <= sum_add[LEN_W-1:0];
                end
                div_rem_reg <= DIV_W'(i_reg) + 1'b1;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_rem_reg < divisor))
        else $error("divider remainder not below divisor");

    a_final_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && final_reg) |-> (step_reg >= MS_Y1))
        else $error("closing chord ran weight steps");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg == ST_DIV || state_reg == ST_MUL))
        else $error("engine did not start after pop");

    a_sample_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (i_reg != '0 && i_reg <= job_reg.n))
        else $error("sample index out of range");

endmodule

`default_nettype wire

// ----- test/bca_checker.sv -----
// checker: predicts the arc length of each request and compares the results
module bca_checker (
    input  logic        clk,
    input  logic        rst_n,
    bca_req_if.sink     req,
    bca_rsp_if.sink     rsp,
    output int          errors,
    output int          pending
);
    import bca_pkg::*;

    rsp_t length_q[$];

    function automatic longint round_q32(longint acc);
        longint q;
        q = acc + (longint'(1) << 31);
        return q >>> 32;
    endfunction

    function automatic longint chord_len(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        dx = bx - ax;
        dy = by - ay;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        v = dx * dx + dy * dy;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic rsp_t polyline_length(req_t r);
        longint cx[4];
        longint cy[4];
        longint unsigned w[4];
        longint unsigned t;
        longint unsigned u;
        longint unsigned sum;
        longint lx;
        longint ly;
        longint px;
        longint py;
        int n;
        rsp_t o;
        cx[0] = r.start_x;  cy[0] = r.start_y;
        cx[1] = r.ctrl_a_x; cy[1] = r.ctrl_a_y;
        cx[2] = r.ctrl_b_x; cy[2] = r.ctrl_b_y;
        cx[3] = r.end_x;    cy[3] = r.end_y;
        n = r.sample_count;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        sum = 0;
        lx = cx[0];
        ly = cy[0];
        for (int i = 1; i <= n; i++)
        begin
            t = (longint'(i) << 16) / (n + 1);
            u = 65536 - t;
            w[0] = u * u * u;
            w[1] = 3 * u * u * t;
            w[2] = 3 * u * t * t;
            w[3] = t * t * t;
            px = 0;
            py = 0;
            for (int k = 0; k < 4; k++)
            begin
                w[k] = (w[k] + 32768) >> 16;
                px += longint'(w[k]) * cx[k];
                py += longint'(w[k]) * cy[k];
            end
            px = round_q32(px);
            py = round_q32(py);
            sum += chord_len(lx, ly, px, py);
            lx = px;
            ly = py;
        end
        sum += chord_len(lx, ly, cx[3], cy[3]);
        if (sum >= LEN_MAX)
        begin
            o.arc_length = LEN_MAX;
            o.saturated  = 1'b1;
        end
        else
        begin
            o.arc_length = LEN_W'(sum);
            o.saturated  = 1'b0;
        end
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    assign pending = length_q.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                length_q.push_back(polyline_length(req.data));
            if (rsp.valid && rsp.ready)
            begin
                if (length_q.size() == 0)
                    report("unexpected result", rsp.data.arc_length, 0);
                else
                begin
                    want = length_q.pop_front();
                    if (rsp.data.arc_length !== want.arc_length)
                        report("arc_length", rsp.data.arc_length, want.arc_length);
                    if (rsp.data.saturated !== want.saturated)
                        report("saturated", rsp.data.saturated, want.saturated);
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
// testbench top: drives curve requests, applies backpressure and gives the verdict
module tb;
    import bca_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   send_idle;
    int   recv_stall;
    bit   hold_off;

    bca_req_if req ();
    bca_rsp_if rsp ();

    cubic_bezier_arc_length_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    bca_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                     .errors(errors), .pending(pending));

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver ready, with random stalls and a long hold-off
    always @(negedge clk)
    begin
        if (hold_off)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom_range(4095)) - coord_t'(2048);
            1: return coord_t'($urandom());
            default: return coord_t'($urandom_range(200000)) - coord_t'(100000);
        endcase
    endfunction

    function automatic req_t rand_curve();
        req_t r;
        int m;
        m = $urandom_range(2);
        r.start_x = rand_coord(m);  r.start_y = rand_coord(m);
        r.ctrl_a_x = rand_coord(m); r.ctrl_a_y = rand_coord(m);
        r.ctrl_b_x = rand_coord(m); r.ctrl_b_y = rand_coord(m);
        r.end_x = rand_coord(m);    r.end_y = rand_coord(m);
        if ($urandom_range(19) == 0)
            r.sample_count = N_W'($urandom());
        else
            r.sample_count = N_W'($urandom_range(12));
        return r;
    endfunction

    // valid stays high after a request so that the next one can follow at once
    task automatic send(req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_corner(coord_t a, coord_t b, coord_t c, coord_t d, logic [N_W-1:0] n);
        req_t r;
        r.start_x = a;  r.start_y = b;
        r.ctrl_a_x = c; r.ctrl_a_y = d;
        r.ctrl_b_x = b; r.ctrl_b_y = a;
        r.end_x = d;    r.end_y = c;
        r.sample_count = n;
        send(r);
    endtask

    localparam coord_t CMIN = coord_t'(24'h800000);
    localparam coord_t CMAX = coord_t'(24'h7fffff);

    initial
    begin
        cycles     = 0;
        send_idle  = 0;
        recv_stall = 0;
        hold_off   = 1'b0;
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.data   = '0;
        rsp.ready  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        send_corner(0, 0, 0, 0, 0);
        send_corner(CMIN, CMAX, CMIN, CMAX, 0);
        send_corner(CMAX, CMIN, CMAX, CMIN, 0);
        send_corner(CMIN, CMIN, CMAX, CMAX, 1);
        send_corner(CMIN, CMAX, CMAX, CMIN, 255);
        send_corner(CMAX, CMAX, CMIN, CMIN, 200);
        send_corner(-1, 1, 24'sd256, -24'sd256, 7);
        send_corner(24'sd1000, -24'sd5000, 24'sd77, 24'sd3, 254);
        send_corner(CMIN, 0, CMAX, 0, 3);
        send_corner(24'h555555, 24'haaaaaa, 24'h0f0f0f, 24'hf0f0f0, 2);
        send_corner(24'haaaaaa, 24'h555555, 24'hf0f0f0, 24'h0f0f0f, 128);

        // random phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 54; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 54; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            if (phase == 2)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 100; i++)
                send(rand_curve());
            if (phase == 0)
            begin
                req.valid <= 1'b0;
                repeat (20) @(negedge clk);
            end
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- cubic_bezier_arc_length_top.f -----
sv/bca_pkg.sv
sv/bca_req_if.sv
sv/bca_rsp_if.sv
sv/bca_front.sv
sv/bca_queue.sv
sv/bca_back.sv
sv/cubic_bezier_arc_length_top.sv
test/bca_checker.sv
test/tb.sv
